// ===== design/yaw_gyro_mag_kalman_fusion_top_macros.svh =====
// Assertion macros for the yaw fusion block.
// Needs nothing else; included by the top level.
`ifndef YAW_GYRO_MAG_KALMAN_FUSION_TOP_MACROS_SVH
`define YAW_GYRO_MAG_KALMAN_FUSION_TOP_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define YGMK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define YGMK_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ygmk_pkg.sv =====
// Shared types, constants and helpers of the yaw fusion block.
// No dependencies.
package ygmk_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_INTERVAL_MS = 1000;
   localparam int MS_PER_S        = 1000;
   localparam int MUL_STEPS       = 32;
   localparam int DIV_STEPS       = 48;

   localparam logic signed [63:0] Q_ONE    = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] Q_HALF   = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] DEG_HALF = 64'sd180 <<< FRAC_BITS;
   localparam logic signed [63:0] DEG_FULL = 64'sd360 <<< FRAC_BITS;

   localparam logic [23:0] PNY_RESET  = 24'd1311;
   localparam logic [23:0] PNB_RESET  = 24'd197;
   localparam logic [23:0] RNH_RESET  = 24'd196608;
   localparam logic [23:0] GAIN_RESET = 24'd3996;

   typedef enum logic [1:0] {
      REG_PNY  = 2'd0,
      REG_PNB  = 2'd1,
      REG_RNH  = 2'd2,
      REG_GAIN = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      OP_QMUL   = 2'd0,
      OP_MULRAW = 2'd1,
      OP_DIV    = 2'd2,
      OP_WRAP   = 2'd3
   } op_type;

   typedef struct packed {
      logic               start;
      op_type             op;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? 64'(-v) : 64'(v);
      return r;
   endfunction

endpackage

// ===== design/yaw_gyro_mag_kalman_fusion_top.sv =====
// Yaw fusion top level: two-state Kalman filter sequencer, registers, ports.
// Depends on ygmk_pkg, ygmk_serial_unit and the macros header.
//
//   channel | direction | handshake             | beat
//   req     | in        | req_valid / req_stall | gyro_raw, mag_heading, interval_ms
//   rsp     | out       | rsp_valid / rsp_stall | fused_heading
//   csr     | in/out    | APB, pready tied high | 4 x 24-bit registers at 4*i
//
// One item at a time through a shared bit-serial unit. The first beat after
// reset only wraps the magnetometer heading to set the yaw. Later beats take
// 11 multiplies, 3 divides and 4 wraps, with both gain divides skipped when
// the innovation variance is not positive.
// Synchronous reset sets the filter state and the registers to defaults.
// req_stall is high while a beat is in work; a stalled rsp beat holds while
// the next req beat is taken and worked.
`include "yaw_gyro_mag_kalman_fusion_top_macros.svh"

module yaw_gyro_mag_kalman_fusion_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_gyro_raw,
   input  logic signed [25:0] req_mag_heading,
   input  logic [9:0]         req_interval_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_fused_heading,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [19:0] {
      ST_IDLE = 20'h00001,
      ST_WMAG = 20'h00002,
      ST_DT   = 20'h00004,
      ST_RAW  = 20'h00008,
      ST_M1   = 20'h00010,
      ST_W1   = 20'h00020,
      ST_M2   = 20'h00040,
      ST_M3   = 20'h00080,
      ST_M4   = 20'h00100,
      ST_W2   = 20'h00200,
      ST_D1   = 20'h00400,
      ST_D2   = 20'h00800,
      ST_M5   = 20'h01000,
      ST_W3   = 20'h02000,
      ST_M6   = 20'h04000,
      ST_M7   = 20'h08000,
      ST_M8   = 20'h10000,
      ST_M9   = 20'h20000,
      ST_M10  = 20'h40000,
      ST_DONE = 20'h80000
   } state_type;

   state_type          state_ff, state_in;
   logic               wait_ff, wait_in;
   logic               started_ff, started_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [24:0] rsp_yaw_ff, rsp_yaw_in;

   logic [23:0]        pny_ff, pny_in;
   logic [23:0]        pnb_ff, pnb_in;
   logic [23:0]        rnh_ff, rnh_in;
   logic [23:0]        gain_ff, gain_in;

   logic signed [15:0] gyro_ff, gyro_in;
   logic signed [25:0] mag_ff, mag_in;
   logic [9:0]         ms_ff, ms_in;

   logic signed [31:0] yaw_ff, yaw_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in;
   logic signed [31:0] p01_ff, p01_in;
   logic signed [31:0] p10_ff, p10_in;
   logic signed [31:0] p11_ff, p11_in;
   logic signed [31:0] q00_ff, q00_in;
   logic signed [31:0] q01_ff, q01_in;
   logic signed [31:0] q10_ff, q10_in;
   logic signed [31:0] q11_ff, q11_in;
   logic signed [31:0] dt_ff, dt_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [31:0] k0_ff, k0_in;
   logic signed [31:0] k1_ff, k1_in;
   logic signed [25:0] magw_ff, magw_in;
   logic signed [25:0] y_ff, y_in;
   logic signed [47:0] wx_ff, wx_in;

   ygmk_pkg::cmd_type  cmd;
   ygmk_pkg::sts_type  sts;

   logic               req_take;
   logic               csr_wr;
   logic [9:0]         ms_cl;
   logic signed [63:0] r;
   logic signed [63:0] s_w;
   logic signed [31:0] one_k0;
   logic signed [63:0] pny_s;

   ygmk_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_fused_heading = rsp_yaw_ff;

   assign r      = sts.res;
   assign pny_s  = $signed({40'd0, pny_ff});
   assign s_w    = 64'(q00_ff) + $signed({40'd0, rnh_ff});
   assign one_k0 = ygmk_pkg::sat32(ygmk_pkg::Q_ONE - 64'(k0_ff));

   always_comb begin
      if (ms_ff == 10'd0) begin
         ms_cl = 10'd1;
      end else if (32'(ms_ff) > ygmk_pkg::MAX_INTERVAL_MS) begin
         ms_cl = 10'(ygmk_pkg::MAX_INTERVAL_MS);
      end else begin
         ms_cl = ms_ff;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ygmk_pkg::REG_PNY:  csr_prdata = {8'd0, pny_ff};
         ygmk_pkg::REG_PNB:  csr_prdata = {8'd0, pnb_ff};
         ygmk_pkg::REG_RNH:  csr_prdata = {8'd0, rnh_ff};
         default:            csr_prdata = {8'd0, gain_ff};
      endcase
   end

   // operands of the shared unit for each step
   always_comb begin
      cmd.start = (state_ff != ST_IDLE) && (state_ff != ST_DONE) && !wait_ff;
      cmd.op    = ygmk_pkg::OP_QMUL;
      cmd.a     = '0;
      cmd.b     = '0;
      case (state_ff)
         ST_WMAG: begin
            cmd.op = ygmk_pkg::OP_WRAP;
            cmd.a  = 64'(mag_ff);
         end
         ST_DT: begin
            cmd.op = ygmk_pkg::OP_DIV;
            cmd.a  = ($signed({54'd0, ms_cl}) <<< ygmk_pkg::FRAC_BITS)
                     + 64'(ygmk_pkg::MS_PER_S / 2);
            cmd.b  = 64'(ygmk_pkg::MS_PER_S);
         end
         ST_RAW: begin
            cmd.op = ygmk_pkg::OP_MULRAW;
            cmd.a  = 64'(gyro_ff);
            cmd.b  = $signed({40'd0, gain_ff});
         end
         ST_M1: begin
            cmd.a = 64'(rate_ff);
            cmd.b = 64'(dt_ff);
         end
         ST_W1, ST_W3: begin
            cmd.op = ygmk_pkg::OP_WRAP;
            cmd.a  = 64'(wx_ff);
         end
         ST_M2: begin
            cmd.a = 64'(dt_ff);
            cmd.b = 64'(p11_ff);
         end
         ST_M3: begin
            cmd.a = 64'(dt_ff);
            cmd.b = 64'(tmp_ff);
         end
         ST_M4: begin
            cmd.a = $signed({40'd0, pnb_ff});
            cmd.b = 64'(dt_ff);
         end
         ST_W2: begin
            cmd.op = ygmk_pkg::OP_WRAP;
            cmd.a  = 64'(magw_ff) - 64'(yaw_ff);
         end
         ST_D1: begin
            cmd.op = ygmk_pkg::OP_DIV;
            cmd.a  = 64'(q00_ff) <<< ygmk_pkg::FRAC_BITS;
            cmd.b  = s_w;
         end
         ST_D2: begin
            cmd.op = ygmk_pkg::OP_DIV;
            cmd.a  = 64'(q10_ff) <<< ygmk_pkg::FRAC_BITS;
            cmd.b  = s_w;
         end
         ST_M5: begin
            cmd.a = 64'(k0_ff);
            cmd.b = 64'(y_ff);
         end
         ST_M6: begin
            cmd.a = 64'(k1_ff);
            cmd.b = 64'(y_ff);
         end
         ST_M7: begin
            cmd.a = 64'(one_k0);
            cmd.b = 64'(q00_ff);
         end
         ST_M8: begin
            cmd.a = 64'(one_k0);
            cmd.b = 64'(q01_ff);
         end
         ST_M9: begin
            cmd.a = 64'(k1_ff);
            cmd.b = 64'(q00_ff);
         end
         ST_M10: begin
            cmd.a = 64'(k1_ff);
            cmd.b = 64'(q01_ff);
         end
         default: begin
            cmd.a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      pny_in  = pny_ff;
      pnb_in  = pnb_ff;
      rnh_in  = rnh_ff;
      gain_in = gain_ff;
      gyro_in = gyro_ff;
      mag_in  = mag_ff;
      ms_in   = ms_ff;
      yaw_in  = yaw_ff;
      bias_in = bias_ff;
      p00_in  = p00_ff;
      p01_in  = p01_ff;
      p10_in  = p10_ff;
      p11_in  = p11_ff;
      q00_in  = q00_ff;
      q01_in  = q01_ff;
      q10_in  = q10_ff;
      q11_in  = q11_ff;
      dt_in   = dt_ff;
      rate_in = rate_ff;
      tmp_in  = tmp_ff;
      k0_in   = k0_ff;
      k1_in   = k1_ff;
      magw_in = magw_ff;
      y_in    = y_ff;
      wx_in   = wx_ff;

      if (csr_wr) begin
         case (csr_paddr[3:2])
            ygmk_pkg::REG_PNY: pny_in  = csr_pwdata[23:0];
            ygmk_pkg::REG_PNB: pnb_in  = csr_pwdata[23:0];
            ygmk_pkg::REG_RNH: rnh_in  = csr_pwdata[23:0];
            default:           gain_in = csr_pwdata[23:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.start) begin
         wait_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               gyro_in  = req_gyro_raw;
               mag_in   = req_mag_heading;
               ms_in    = req_interval_ms;
               state_in = ST_WMAG;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_yaw_in   = yaw_ff[24:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            if (sts.done && wait_ff) begin
               wait_in = 1'b0;
               case (state_ff)
                  ST_WMAG: begin
                     if (!started_ff) begin
                        yaw_in     = 32'(r);
                        bias_in    = '0;
                        p00_in     = 32'(ygmk_pkg::Q_ONE);
                        p01_in     = '0;
                        p10_in     = '0;
                        p11_in     = 32'(ygmk_pkg::Q_ONE);
                        started_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        magw_in  = 26'(r);
                        state_in = ST_DT;
                     end
                  end
                  ST_DT: begin
                     dt_in    = 32'(r);
                     state_in = ST_RAW;
                  end
                  ST_RAW: begin
                     rate_in  = ygmk_pkg::sat32(64'(ygmk_pkg::sat32(r)) - 64'(bias_ff));
                     state_in = ST_M1;
                  end
                  ST_M1: begin
                     wx_in    = 48'(64'(yaw_ff) + r);
                     state_in = ST_W1;
                  end
                  ST_W1: begin
                     yaw_in   = 32'(r);
                     state_in = ST_M2;
                  end
                  ST_M2: begin
                     q01_in   = ygmk_pkg::sat32(64'(p01_ff) - r);
                     q10_in   = ygmk_pkg::sat32(64'(p10_ff) - r);
                     tmp_in   = ygmk_pkg::sat32(r - 64'(p01_ff) - 64'(p10_ff) + pny_s);
                     state_in = ST_M3;
                  end
                  ST_M3: begin
                     q00_in   = ygmk_pkg::sat32(64'(p00_ff) + r);
                     state_in = ST_M4;
                  end
                  ST_M4: begin
                     q11_in   = ygmk_pkg::sat32(64'(p11_ff) + r);
                     state_in = ST_W2;
                  end
                  ST_W2: begin
                     y_in = 26'(r);
                     if (s_w > 64'sd0) begin
                        state_in = ST_D1;
                     end else begin
                        k0_in    = '0;
                        k1_in    = '0;
                        state_in = ST_M5;
                     end
                  end
                  ST_D1: begin
                     k0_in    = 32'(r);
                     state_in = ST_D2;
                  end
                  ST_D2: begin
                     k1_in    = 32'(r);
                     state_in = ST_M5;
                  end
                  ST_M5: begin
                     wx_in    = 48'(64'(yaw_ff) + r);
                     state_in = ST_W3;
                  end
                  ST_W3: begin
                     yaw_in   = 32'(r);
                     state_in = ST_M6;
                  end
                  ST_M6: begin
                     bias_in  = ygmk_pkg::sat32(64'(bias_ff) + r);
                     state_in = ST_M7;
                  end
                  ST_M7: begin
                     p00_in   = ygmk_pkg::sat32(r);
                     state_in = ST_M8;
                  end
                  ST_M8: begin
                     p01_in   = ygmk_pkg::sat32(r);
                     state_in = ST_M9;
                  end
                  ST_M9: begin
                     p10_in   = ygmk_pkg::sat32(64'(q10_ff) - r);
                     state_in = ST_M10;
                  end
                  ST_M10: begin
                     p11_in   = ygmk_pkg::sat32(64'(q11_ff) - r);
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pny_ff       <= ygmk_pkg::PNY_RESET;
         pnb_ff       <= ygmk_pkg::PNB_RESET;
         rnh_ff       <= ygmk_pkg::RNH_RESET;
         gain_ff      <= ygmk_pkg::GAIN_RESET;
         yaw_ff       <= '0;
         bias_ff      <= '0;
         p00_ff       <= 32'(ygmk_pkg::Q_ONE);
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= 32'(ygmk_pkg::Q_ONE);
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         pny_ff       <= pny_in;
         pnb_ff       <= pnb_in;
         rnh_ff       <= rnh_in;
         gain_ff      <= gain_in;
         yaw_ff       <= yaw_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
      end
      rsp_yaw_ff <= rsp_yaw_in;
      gyro_ff    <= gyro_in;
      mag_ff     <= mag_in;
      ms_ff      <= ms_in;
      q00_ff     <= q00_in;
      q01_ff     <= q01_in;
      q10_ff     <= q10_in;
      q11_ff     <= q11_in;
      dt_ff      <= dt_in;
      rate_ff    <= rate_in;
      tmp_ff     <= tmp_in;
      k0_ff      <= k0_in;
      k1_ff      <= k1_in;
      magw_ff    <= magw_in;
      y_ff       <= y_in;
      wx_ff      <= wx_in;
   end

   `YGMK_ASSERT_IMP(a_done_while_waiting, clock, reset, sts.done, wait_ff, "unit result without a pending step")
   `YGMK_ASSERT_IMP(a_idle_not_waiting, clock, reset, state_ff == ST_IDLE, !wait_ff, "idle with a unit step pending")
   `YGMK_ASSERT_IMP(a_yaw_in_range, clock, reset, started_ff, (yaw_ff <= 32'(ygmk_pkg::DEG_HALF)) && (yaw_ff >= -32'(ygmk_pkg::DEG_HALF)), "yaw out of range")
   `YGMK_ASSERT_NXT(a_take_starts_work, clock, reset, req_take, state_ff == ST_WMAG, "accepted beat not started")

endmodule

// ===== design/ygmk_serial_unit.sv =====
// Bit-serial arithmetic unit: rounded fixed-point multiply, raw multiply,
// signed divide and angle wrap. Uses ygmk_pkg.
module ygmk_serial_unit (
   input  logic               clock,
   input  logic               reset,
   input  ygmk_pkg::cmd_type  cmd,
   output ygmk_pkg::sts_type  sts
);

   logic               run_ff, run_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   ygmk_pkg::op_type   op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [63:0]        sh_ff, sh_in;
   logic [63:0]        opnd_ff, opnd_in;
   logic [63:0]        acc_ff, acc_in;
   logic [33:0]        rem_ff, rem_in;
   logic signed [63:0] res_ff, res_in;

   logic [34:0]        den_w;
   logic [34:0]        trial;
   logic [34:0]        diff;
   logic               ge;
   logic signed [63:0] sacc;
   logic signed [63:0] x_w;
   logic signed [63:0] m_w;
   logic signed [63:0] r_w;

   assign den_w = (op_ff == ygmk_pkg::OP_WRAP) ? 35'(ygmk_pkg::DEG_FULL) : opnd_ff[34:0];
   assign trial = {rem_ff, sh_ff[ygmk_pkg::DIV_STEPS-1]};
   assign diff  = trial - den_w;
   assign ge    = trial >= den_w;
   assign sacc  = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
   assign x_w   = $signed(opnd_ff);
   assign m_w   = $signed({30'd0, rem_ff});
   assign r_w   = (x_w < 0 && m_w != 0) ? ygmk_pkg::DEG_FULL - m_w : m_w;

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (cmd.start) begin
         run_in  = 1'b1;
         op_in   = cmd.op;
         acc_in  = '0;
         rem_in  = '0;
         sh_in   = ygmk_pkg::abs64(cmd.a);
         case (cmd.op)
            ygmk_pkg::OP_QMUL, ygmk_pkg::OP_MULRAW: begin
               cnt_in  = 6'(ygmk_pkg::MUL_STEPS);
               opnd_in = ygmk_pkg::abs64(cmd.b);
               neg_in  = cmd.a[63] ^ cmd.b[63];
            end
            ygmk_pkg::OP_DIV: begin
               cnt_in  = 6'(ygmk_pkg::DIV_STEPS);
               opnd_in = cmd.b;
               neg_in  = cmd.a[63];
            end
            default: begin
               cnt_in  = 6'(ygmk_pkg::DIV_STEPS);
               opnd_in = cmd.a;
               neg_in  = cmd.a[63];
            end
         endcase
      end else if (run_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
         case (op_ff)
            ygmk_pkg::OP_QMUL, ygmk_pkg::OP_MULRAW: begin
               acc_in  = acc_ff + (sh_ff[0] ? opnd_ff : 64'd0);
               opnd_in = opnd_ff << 1;
               sh_in   = sh_ff >> 1;
            end
            default: begin
               rem_in = ge ? diff[33:0] : trial[33:0];
               acc_in = {acc_ff[62:0], ge};
               sh_in  = sh_ff << 1;
            end
         endcase
      end else if (fin_ff) begin
         done_in = 1'b1;
         case (op_ff)
            ygmk_pkg::OP_QMUL:   res_in = (sacc + ygmk_pkg::Q_HALF) >>> ygmk_pkg::FRAC_BITS;
            ygmk_pkg::OP_MULRAW: res_in = sacc;
            ygmk_pkg::OP_DIV:    res_in = 64'(ygmk_pkg::sat32(sacc));
            default: begin
               if (x_w > ygmk_pkg::DEG_HALF) begin
                  res_in = (r_w > ygmk_pkg::DEG_HALF) ? r_w - ygmk_pkg::DEG_FULL : r_w;
               end else if (x_w < -ygmk_pkg::DEG_HALF) begin
                  res_in = (r_w >= ygmk_pkg::DEG_HALF) ? r_w - ygmk_pkg::DEG_FULL : r_w;
               end else begin
                  res_in = x_w;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      sh_ff   <= sh_in;
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign sts.done = done_ff;
   assign sts.res  = res_ff;

endmodule
